[rtl/gei_pkg.sv]
// Shared types and constants of the GPIO edge-detect interrupt unit.
`timescale 1ns / 1ps
`default_nettype none

package gei_pkg;

   localparam int BANK_COUNT = 4;
   localparam int BANK_BITS  = 2;
   localparam int BANK_WIDTH = 32;
   localparam int BIT_BITS   = 5;
   localparam int PIN_BITS   = 7;

   localparam logic [BANK_WIDTH-1:0] BANK0_SKIP_MASK = 32'h0000_0003;

   typedef enum logic [2:0] {
      REQ_ENABLE  = 3'd0,
      REQ_DISABLE = 3'd1,
      REQ_CLEAR   = 3'd2,
      REQ_SAMPLE  = 3'd3,
      REQ_SERVICE = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      MODE_RISE  = 2'd0,
      MODE_FALL  = 2'd1,
      MODE_BOTH  = 2'd2,
      MODE_KEEP  = 2'd3
   } mode_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [BANK_WIDTH-1:0] rise;
      logic [BANK_WIDTH-1:0] fall;
      logic [BANK_WIDTH-1:0] detect;
      logic [BANK_WIDTH-1:0] level;
   } bank_entry_type;

   typedef struct packed {
      logic load;
      logic advance;
   } scan_ctl_type;

endpackage : gei_pkg

`default_nettype wire

[rtl/gei_bank_mem.sv]
// Bank state memory: one entry per bank, synchronous read, valid bits for reset.
`timescale 1ns / 1ps
`default_nettype none

module gei_bank_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [gei_pkg::BANK_BITS-1:0] rd_addr,
   output gei_pkg::bank_entry_type            rd_data,
   input  wire logic                          wr_en,
   input  wire logic [gei_pkg::BANK_BITS-1:0] wr_addr,
   input  wire gei_pkg::bank_entry_type       wr_data
);
   import gei_pkg::*;

   bank_entry_type              bank_mem_ff [BANK_COUNT];
   bank_entry_type              rd_data_ff;
   logic                        rd_valid_ff;
   logic [BANK_COUNT-1:0]       valid_ff;
   logic [BANK_COUNT-1:0]       valid_in;

   // Memory array and its registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= bank_mem_ff[rd_addr];
   end

   // An entry that was never written since reset reads as all zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule : gei_bank_mem

`default_nettype wire

[rtl/gei_scanner.sv]
// Service scanner: lists the pending pins of one bank from the highest downward.
`timescale 1ns / 1ps
`default_nettype none

module gei_scanner (
   input  wire logic                           clock,
   input  wire gei_pkg::scan_ctl_type          ctl,
   input  wire logic [gei_pkg::BANK_BITS-1:0]  load_bank,
   input  wire logic [gei_pkg::BANK_WIDTH-1:0] load_detect,
   output logic      [gei_pkg::PIN_BITS-1:0]   pending_pin,
   output logic                                found,
   output logic                                last
);
   import gei_pkg::*;

   logic [BANK_WIDTH-1:0] word_ff;
   logic [BANK_WIDTH-1:0] word_in;
   logic [BANK_BITS-1:0]  bank_ff;
   logic [BIT_BITS-1:0]   hi_idx;
   logic [BANK_WIDTH-1:0] rest;

   // Highest set bit of the remaining word.
   always_comb begin
      hi_idx = '0;
      for (int b = 0; b < BANK_WIDTH; b++) begin
         if (word_ff[b]) begin
            hi_idx = BIT_BITS'(b);
         end
      end
   end

   assign rest        = word_ff & ~({{(BANK_WIDTH-1){1'b0}}, 1'b1} << hi_idx);
   assign found       = |word_ff;
   assign last        = ~|rest;
   assign pending_pin = found ? {bank_ff, hi_idx} : '0;

   always_comb begin
      word_in = word_ff;
      if (ctl.load) begin
         // Pins 0 and 1 of bank 0 are never listed.
         word_in = (load_bank == '0) ? (load_detect & ~BANK0_SKIP_MASK) : load_detect;
      end else if (ctl.advance) begin
         word_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (ctl.load) begin
         bank_ff <= load_bank;
      end
   end

endmodule : gei_scanner

`default_nettype wire

[rtl/gpio_edge_detect_interrupt_unit.sv]
// Top level of the GPIO edge-detect interrupt unit: control, update logic and instances.
`timescale 1ns / 1ps
`default_nettype none

// Channel        Ports                                              Handshake
// request        req_type, req_pin, req_mode, req_level, req_bank   start high, busy low
// response       rsp_pending_pin, rsp_found, rsp_last               rsp_strobe, one cycle
//
// Every request reads its bank entry from the bank memory, which has a registered read
// port, and then writes it back. A request other than a service passes through ST_ACCESS
// and back to ST_IDLE, and busy stays high until then. A service passes ST_ACCESS and then
// emits its n results (at least one) in ST_EMIT, one per cycle, from the scanner.
// Reset is synchronous and active high; the bank state reads as zero after it, with no
// clearing pass. The receiver cannot stall: each result is shown for exactly one cycle.

module gpio_edge_detect_interrupt_unit #(
   parameter int PIN_COUNT = 121
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [2:0]                    req_type,
   input  wire logic [gei_pkg::PIN_BITS-1:0]  req_pin,
   input  wire logic [1:0]                    req_mode,
   input  wire logic                          req_level,
   input  wire logic [gei_pkg::BANK_BITS-1:0] req_bank,
   output logic                               rsp_strobe,
   output logic      [gei_pkg::PIN_BITS-1:0]  rsp_pending_pin,
   output logic                               rsp_found,
   output logic                               rsp_last
);
   import gei_pkg::*;

   // Pins at or above this limit are ignored by every per-pin request.
   localparam logic [PIN_BITS:0] PIN_LIMIT = (PIN_BITS+1)'(PIN_COUNT);

   state_type             state_ff;
   state_type             state_in;

   // The request captured when a transaction is accepted.
   req_code_type          type_ff;
   logic [PIN_BITS-1:0]   pin_ff;
   mode_code_type         mode_ff;
   logic                  level_ff;
   logic [BANK_BITS-1:0]  bank_ff;

   logic                  accept;
   logic [BANK_BITS-1:0]  rd_addr;
   bank_entry_type        rd_entry;
   bank_entry_type        wr_entry;
   logic                  wr_en;
   logic                  pin_ok;
   logic [BANK_WIDTH-1:0] pin_bit;
   logic                  was_high;
   scan_ctl_type          scan_ctl;
   logic                  scan_last;

   assign accept = start && !busy;

   // The read is launched at the accepting edge: a service reads the bank it names,
   // every other request reads the bank that holds its pin.
   assign rd_addr = (req_code_type'(req_type) == REQ_SERVICE) ? req_bank
                                                                : req_pin[PIN_BITS-1:BIT_BITS];

   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff  <= req_code_type'(req_type);
         pin_ff   <= req_pin;
         mode_ff  <= mode_code_type'(req_mode);
         level_ff <= req_level;
         bank_ff  <= req_bank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer. The bank memory is only ever accessed by one transaction at a time,
   // so the write-back of one request is complete before the next read is launched.
   always_comb begin
      state_in         = state_ff;
      busy             = 1'b1;
      wr_en            = 1'b0;
      scan_ctl.load    = 1'b0;
      scan_ctl.advance = 1'b0;
      rsp_strobe       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               state_in = ST_ACCESS;
            end
         end
         ST_ACCESS: begin
            if (type_ff == REQ_SERVICE) begin
               scan_ctl.load = 1'b1;
               state_in      = ST_EMIT;
            end else begin
               wr_en    = pin_ok;
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            rsp_strobe       = 1'b1;
            scan_ctl.advance = 1'b1;
            if (scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pin_ok   = {1'b0, pin_ff} < PIN_LIMIT;
   assign pin_bit  = {{(BANK_WIDTH-1){1'b0}}, 1'b1} << pin_ff[BIT_BITS-1:0];
   assign was_high = |(rd_entry.level & pin_bit);

   // Read-modify-write of the pin's bit in its bank entry.
   always_comb begin
      wr_entry = rd_entry;
      unique case (type_ff)
         REQ_ENABLE: begin
            case (mode_ff)
               MODE_RISE: begin
                  wr_entry.rise = rd_entry.rise | pin_bit;
                  wr_entry.fall = rd_entry.fall & ~pin_bit;
               end
               MODE_FALL: begin
                  wr_entry.rise = rd_entry.rise & ~pin_bit;
                  wr_entry.fall = rd_entry.fall | pin_bit;
               end
               MODE_BOTH: begin
                  wr_entry.rise = rd_entry.rise | pin_bit;
                  wr_entry.fall = rd_entry.fall | pin_bit;
               end
               default: begin
                  wr_entry = rd_entry;
               end
            endcase
         end
         REQ_DISABLE: begin
            wr_entry.rise = rd_entry.rise & ~pin_bit;
            wr_entry.fall = rd_entry.fall & ~pin_bit;
         end
         REQ_CLEAR: begin
            wr_entry.detect = rd_entry.detect & ~pin_bit;
         end
         REQ_SAMPLE: begin
            // A rising edge counts only when its enable is set, likewise a falling edge.
            if ((!was_high && level_ff && |(rd_entry.rise & pin_bit)) ||
                (was_high && !level_ff && |(rd_entry.fall & pin_bit))) begin
               wr_entry.detect = rd_entry.detect | pin_bit;
            end
            wr_entry.level = level_ff ? (rd_entry.level | pin_bit)
                                      : (rd_entry.level & ~pin_bit);
         end
         default: begin
            wr_entry = rd_entry;
         end
      endcase
   end

   gei_bank_mem u_bank_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_data (rd_entry),
      .wr_en   (wr_en),
      .wr_addr (pin_ff[PIN_BITS-1:BIT_BITS]),
      .wr_data (wr_entry)
   );

   gei_scanner u_scanner (
      .clock       (clock),
      .ctl         (scan_ctl),
      .load_bank   (bank_ff),
      .load_detect (rd_entry.detect),
      .pending_pin (rsp_pending_pin),
      .found       (rsp_found),
      .last        (scan_last)
   );

   assign rsp_last = scan_last;

   // A result only appears while a transaction is in progress.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe outside a transaction");

   // The final result of a service run frees the unit in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_strobe && rsp_last) |=> !busy)
      else $error("unit still busy after the final result");

   // An empty bank yields exactly one result, and it is the final one.
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_strobe && !rsp_found) |-> (rsp_last && rsp_pending_pin == '0))
      else $error("empty-bank result malformed");

   // An accepted transaction always occupies the unit in the following cycle.
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> busy)
      else $error("accepted transaction did not start");

   // The bank memory is never written while results are being emitted.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> !wr_en)
      else $error("bank write during a service run");

endmodule : gpio_edge_detect_interrupt_unit

`default_nettype wire
